### rtl/core/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection tester.
// Used by the classify front end, the queue, the divider back end and the top level.
package rti_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 60;
	localparam int DIST_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX0 = 2'd0,
		REG_EDGE1   = 2'd1,
		REG_EDGE2   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MISS_NONE   = 2'd0,
		MISS_FACING = 2'd1,
		MISS_U      = 2'd2,
		MISS_V      = 2'd3
	} miss_reason_t;

endpackage

### rtl/core/ray_triangle_intersect.sv
// Single-sided ray/triangle intersection tester, top level.
// Holds the triangle registers and ties front end, queue and divider back end.
//
// Usage: write vertex0 (index 0), edge1 (1) and edge2 (2) through the
// write port while idle; each is three packed signed Q8.12 components, x low.
// Each request on the input channel is one ray (origin and direction). One
// result leaves per request, in order: hit, miss reason and distance t
// in Q20.12, truncated toward zero and saturated; zero on a miss.
// Throughput: one ray per cycle while the input is not stalled. A ray passes
// the multiply front end (operands and tvec, pvec and qvec, dot products, classify),
// then the queue, then one divider stage per quotient bit (numerator width plus fraction bits) plus an output register.
// The depth of the one-bit-per-stage divider sets the latency.
// Reset clears the triangle registers to zero and empties every stage.
// When the receiver stalls, the divider holds and the queue absorbs the
// front end's requests in flight; once it fills, the input is stalled.
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COMP_WIDTH = 20,
	parameter int FRAC_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COMP_WIDTH-1:0] origin_x,
	input  logic signed [COMP_WIDTH-1:0] origin_y,
	input  logic signed [COMP_WIDTH-1:0] origin_z,
	input  logic signed [COMP_WIDTH-1:0] dir_x,
	input  logic signed [COMP_WIDTH-1:0] dir_y,
	input  logic signed [COMP_WIDTH-1:0] dir_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [1:0]                   miss_reason,
	output logic signed [DIST_W-1:0]     distance
);

	localparam int NUM_W = 3*COMP_WIDTH + 8;

	logic [CFG_DATA_W-1:0] vertex0_q, edge1_q, edge2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex0_q <= '0;
			edge1_q <= '0;
			edge2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VERTEX0: vertex0_q <= cfg_data;
				REG_EDGE1:   edge1_q <= cfg_data;
				REG_EDGE2:   edge2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic f_valid, f_stall, b_valid, b_stall;
	miss_reason_t f_reason, b_reason;
	logic signed [NUM_W-1:0] f_nt, f_det, b_nt, b_det;

	rti_front #(.COMP_WIDTH(COMP_WIDTH), .NUM_W(NUM_W)) u_front (
		.clk, .arst_n, .vertex0_q, .edge1_q, .edge2_q,
		.in_valid, .in_stall,
		.ox(origin_x), .oy(origin_y), .oz(origin_z),
		.dx(dir_x), .dy(dir_y), .dz(dir_z),
		.out_valid(f_valid), .out_stall(f_stall),
		.out_reason(f_reason), .out_nt(f_nt), .out_det(f_det)
	);

	rti_queue #(.NUM_W(NUM_W), .DEPTH(8)) u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_stall(f_stall),
		.in_reason(f_reason), .in_nt(f_nt), .in_det(f_det),
		.out_valid(b_valid), .out_stall(b_stall),
		.out_reason(b_reason), .out_nt(b_nt), .out_det(b_det)
	);

	rti_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk, .arst_n,
		.in_valid(b_valid), .in_stall(b_stall),
		.in_reason(b_reason), .in_nt(b_nt), .in_det(b_det),
		.out_valid, .out_stall, .hit, .miss_reason, .distance
	);

endmodule

### rtl/core/rti_front.sv
// Front end: computes det, u, v and t numerators in a multiply pipeline and classifies.
// Depends on rti_pkg. Advances only when its final stage is free or moving on.
module rti_front import rti_pkg::*; #(
	parameter int COMP_WIDTH = 20,
	parameter int NUM_W = 3*COMP_WIDTH + 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [CFG_DATA_W-1:0]        vertex0_q,
	input  logic [CFG_DATA_W-1:0]        edge1_q,
	input  logic [CFG_DATA_W-1:0]        edge2_q,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COMP_WIDTH-1:0] ox,
	input  logic signed [COMP_WIDTH-1:0] oy,
	input  logic signed [COMP_WIDTH-1:0] oz,
	input  logic signed [COMP_WIDTH-1:0] dx,
	input  logic signed [COMP_WIDTH-1:0] dy,
	input  logic signed [COMP_WIDTH-1:0] dz,
	output logic                         out_valid,
	input  logic                         out_stall,
	output miss_reason_t                 out_reason,
	output logic signed [NUM_W-1:0]      out_nt,
	output logic signed [NUM_W-1:0]      out_det
);

	localparam int V_W = COMP_WIDTH + 1;
	localparam int P_W = 2*V_W + 2;

	function automatic logic signed [V_W-1:0] comp(input logic [CFG_DATA_W-1:0] r, input int k);
		logic [3*COMP_WIDTH-1:0] ext;
		ext = '0;
		for (int i = 0; i < 3*COMP_WIDTH; i++)
			if (i < 64 && i < CFG_DATA_W)
				ext[i] = r[i];
		return V_W'($signed(ext[k*COMP_WIDTH +: COMP_WIDTH]));
	endfunction

	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Stage 1: operands and tvec.
	logic v_s1;
	logic signed [V_W-1:0] d_s1 [3];
	logic signed [V_W-1:0] t_s1 [3];
	// Stage 2: pvec and qvec.
	logic v_s2;
	logic signed [V_W-1:0] d_s2 [3];
	logic signed [P_W-1:0] p_s2 [3];
	logic signed [P_W-1:0] q_s2 [3];
	logic signed [V_W-1:0] t_s2 [3];
	// Stage 3: dot products.
	logic v_s3;
	logic signed [NUM_W-1:0] det_s3, nu_s3, nv_s3, nt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= V_W'(dx);
			d_s1[1] <= V_W'(dy);
			d_s1[2] <= V_W'(dz);
			t_s1[0] <= V_W'(ox) - comp(vertex0_q, 0);
			t_s1[1] <= V_W'(oy) - comp(vertex0_q, 1);
			t_s1[2] <= V_W'(oz) - comp(vertex0_q, 2);
			for (int k = 0; k < 3; k++) begin
				p_s2[k] <= P_W'(d_s1[(k+1)%3] * comp(edge2_q, (k+2)%3))
					- P_W'(d_s1[(k+2)%3] * comp(edge2_q, (k+1)%3));
				q_s2[k] <= P_W'(t_s1[(k+1)%3] * comp(edge1_q, (k+2)%3))
					- P_W'(t_s1[(k+2)%3] * comp(edge1_q, (k+1)%3));
			end
			d_s2 <= d_s1;
			t_s2 <= t_s1;
			det_s3 <= NUM_W'(comp(edge1_q, 0) * p_s2[0]) + NUM_W'(comp(edge1_q, 1) * p_s2[1])
				+ NUM_W'(comp(edge1_q, 2) * p_s2[2]);
			nu_s3 <= NUM_W'(t_s2[0] * p_s2[0]) + NUM_W'(t_s2[1] * p_s2[1])
				+ NUM_W'(t_s2[2] * p_s2[2]);
			nv_s3 <= NUM_W'(d_s2[0] * q_s2[0]) + NUM_W'(d_s2[1] * q_s2[1])
				+ NUM_W'(d_s2[2] * q_s2[2]);
			nt_s3 <= NUM_W'(comp(edge2_q, 0) * q_s2[0]) + NUM_W'(comp(edge2_q, 1) * q_s2[1])
				+ NUM_W'(comp(edge2_q, 2) * q_s2[2]);
			out_det <= det_s3;
			out_nt <= nt_s3;
			if (det_s3 <= 0)
				out_reason <= MISS_FACING;
			else if (nu_s3 < 0 || nu_s3 > det_s3)
				out_reason <= MISS_U;
			else if (nv_s3 < 0 || (nu_s3 + nv_s3) > det_s3)
				out_reason <= MISS_V;
			else
				out_reason <= MISS_NONE;
		end
	end

endmodule

### rtl/core/rti_queue.sv
// Small request queue between the classify front end and the divider back end.
// Depends on rti_pkg for the miss reason type.
module rti_queue import rti_pkg::*; #(
	parameter int NUM_W = 68,
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  miss_reason_t            in_reason,
	input  logic signed [NUM_W-1:0] in_nt,
	input  logic signed [NUM_W-1:0] in_det,
	output logic                    out_valid,
	input  logic                    out_stall,
	output miss_reason_t            out_reason,
	output logic signed [NUM_W-1:0] out_nt,
	output logic signed [NUM_W-1:0] out_det
);

	localparam int A_W = $clog2(DEPTH);

	miss_reason_t            rsn_q [DEPTH];
	logic signed [NUM_W-1:0] nt_q  [DEPTH];
	logic signed [NUM_W-1:0] det_q [DEPTH];
	logic [A_W-1:0] wp_q, rp_q;
	logic [A_W:0]   cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == (A_W+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign out_reason = rsn_q[rp_q];
	assign out_nt = nt_q[rp_q];
	assign out_det = det_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (A_W+1)'(push) - (A_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsn_q[wp_q] <= in_reason;
			nt_q[wp_q] <= in_nt;
			det_q[wp_q] <= in_det;
		end
	end

endmodule

### rtl/core/rti_div.sv
// Back end: pipelined restoring divider for t = nt * 2^FRAC_BITS / det, one bit a stage.
// Depends on rti_pkg. Truncates toward zero and saturates to 32 bits.
module rti_div import rti_pkg::*; #(
	parameter int NUM_W = 68,
	parameter int FRAC_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  miss_reason_t            in_reason,
	input  logic signed [NUM_W-1:0] in_nt,
	input  logic signed [NUM_W-1:0] in_det,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic [1:0]              miss_reason,
	output logic signed [DIST_W-1:0] distance
);

	// Quotient has at most 33 significant bits before saturation; bits above
	// are folded into a sticky overflow flag.
	localparam int DV_W = NUM_W + FRAC_BITS;
	localparam int Q_W = DIST_W + 1;
	localparam int STG = DV_W;

	logic                 v_s    [STG+1];
	miss_reason_t         rs_s   [STG+1];
	logic                 ng_s   [STG+1];
	logic                 ov_s   [STG+1];
	logic [NUM_W-1:0]     den_s  [STG+1];
	logic [DV_W-1:0]      dvd_s  [STG+1];
	logic [NUM_W:0]       rem_s  [STG+1];
	logic [Q_W-1:0]       q_s    [STG+1];
	logic adv;

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_comb begin
		v_s[0] = in_valid;
		rs_s[0] = in_reason;
		ng_s[0] = in_nt[NUM_W-1];
		ov_s[0] = 1'b0;
		den_s[0] = in_det;
		dvd_s[0] = {(in_nt[NUM_W-1] ? NUM_W'(-in_nt) : NUM_W'(in_nt)), FRAC_BITS'(0)};
		rem_s[0] = '0;
		q_s[0] = '0;
	end

	for (genvar g = 0; g < STG; g++) begin : g_stage
		logic [NUM_W:0] r;
		logic [NUM_W+1:0] diff;
		always_comb begin
			r = {rem_s[g][NUM_W-1:0], dvd_s[g][DV_W-1-g]};
			diff = {1'b0, r} - {2'b0, den_s[g]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else if (adv) v_s[g+1] <= v_s[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rs_s[g+1] <= rs_s[g];
				ng_s[g+1] <= ng_s[g];
				den_s[g+1] <= den_s[g];
				dvd_s[g+1] <= dvd_s[g];
				ov_s[g+1] <= ov_s[g] || q_s[g][Q_W-1];
				q_s[g+1] <= {q_s[g][Q_W-2:0], !diff[NUM_W+1]};
				rem_s[g+1] <= diff[NUM_W+1] ? r : diff[NUM_W:0];
			end
		end
	end

	logic [Q_W-1:0] qf;
	logic ovf;
	assign qf = q_s[STG];
	assign ovf = ov_s[STG] || qf[Q_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s[STG];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit <= (rs_s[STG] == MISS_NONE);
			miss_reason <= rs_s[STG];
			if (rs_s[STG] != MISS_NONE)
				distance <= '0;
			else if (ng_s[STG])
				distance <= (ovf || qf[DIST_W-1]) ? {1'b1, {(DIST_W-1){1'b0}}}
					: -$signed(qf[DIST_W-1:0]);
			else
				distance <= (ovf || qf[DIST_W-1]) ? {1'b0, {(DIST_W-1){1'b1}}}
					: $signed(qf[DIST_W-1:0]);
		end
	end

endmodule
